[hdl/lslf_pkg.sv]
// Shared types and constants for the least-squares line fit block.
// Used by the datapath, the controller and the divider.
// No dependencies.
`default_nettype none

package lslf_pkg;

	// Field widths of the point and result beats
	localparam int X_W     = 16;
	localparam int Y_W     = 16;
	localparam int RES_W   = 32;
	// y is Q8.8, results are Q16.16: quotients are scaled by 2^8
	localparam int FRAC_SH = 8;

	localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
	localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

	// Product slots of the final computation, in issue order
	localparam logic [2:0] MUL_N_SXX   = 3'd0;
	localparam logic [2:0] MUL_SX_SX   = 3'd1;
	localparam logic [2:0] MUL_N_SXY   = 3'd2;
	localparam logic [2:0] MUL_SX_SY   = 3'd3;
	localparam logic [2:0] MUL_SY_SXX  = 3'd4;
	localparam logic [2:0] MUL_SX_SXY  = 3'd5;
	localparam logic [2:0] MUL_LAST    = MUL_SX_SXY;

	// Quotient slots
	localparam logic DIV_SLOPE = 1'b0;
	localparam logic DIV_ICPT  = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic       acc_en;
		logic       acc_clr;
		logic       mul_start;
		logic       mul_store;
		logic [2:0] mul_sel;
		logic       diff_en;
		logic       div_start;
		logic       div_store;
		logic       div_sel;
		logic       out_load;
	} lslf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic den_pos;
	} lslf_sts_t;

endpackage

`default_nettype wire

[hdl/least_squares_line_fit.sv]
// Least-squares straight-line fit over a stream of points.
// Input beats (s_*) carry one point each: x (signed integer) and y (signed
// Q8.8); s_tlast marks the last point of a data set. Points are accumulated
// one per cycle while s_tready is high, into the count and the sums of x, y,
// x*y and x*x; points past MAX_POINTS are dropped, but a dropped last point
// still closes the set. After the last point the block drops s_tready and
// computes six products on a shift-add multiplier, the denominator and
// numerators, then, unless the fit is degenerate, two quotients on a
// restoring divider. The sums are cleared for the next set.
// One output beat per set: slope and intercept in Q16.16, truncated toward
// zero and saturated, with m_tuser set when the denominator is zero (values
// then zero). The result waits in an output register; while it is stalled the
// block keeps accepting points of the next set, and only holds its next result.
// Reset clears the sums, drops m_tvalid and raises s_tready.
// Depends on lslf_pkg, lslf_ctrl, lslf_datapath.
`default_nettype none

module least_squares_line_fit
	import lslf_pkg::*;
#(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [X_W+Y_W-1:0]    s_tdata,   // [15:0] point_x, [31:16] point_y
	input  wire logic                  s_tlast,   // is_last
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [2*RES_W-1:0]         m_tdata,   // [31:0] slope, [63:32] intercept
	output logic                       m_tuser    // degenerate
);

	lslf_cmd_t cmd;
	lslf_sts_t sts;

	lslf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lslf_datapath #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.out_data (m_tdata),
		.out_degen(m_tuser)
	);

endmodule

`default_nettype wire

[hdl/lslf_mul.sv]
// Sequential shift-add multiplier: one multiplier bit per cycle, sign applied at the end.
// Standalone; instantiated by lslf_datapath.
`default_nettype none

module lslf_mul #(
	parameter int AW = 44,
	parameter int BW = 28
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [AW-1:0]        a_mag,
	input  wire logic [BW-1:0]        b_mag,
	input  wire logic                 neg,
	output logic                      done,
	output logic [AW+BW:0]            prod
);

	localparam int PW = AW + BW + 1;
	localparam int CW = $clog2(BW);
	localparam logic [CW-1:0] LAST = CW'(BW - 1);

	logic          busy_q;
	logic          fin_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] acc_q;
	logic          neg_q;
	logic [PW-1:0] prod_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a_mag);
			b_q   <= b_mag;
			acc_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
		if (fin_q)
			prod_q <= neg_q ? (~acc_q + PW'(1)) : acc_q;
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

[hdl/lslf_div.sv]
// Restoring divider: (|num| * 2^8) / den, one quotient bit per cycle, Q16.16 saturation.
// Depends on lslf_pkg; instantiated by lslf_datapath.
`default_nettype none

module lslf_div
	import lslf_pkg::*;
#(
	parameter int DW = 74
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DW-1:0]    num,   // two's complement
	input  wire logic [DW-1:0]    den,   // positive
	output logic                  done,
	output logic [RES_W-1:0]      quo
);

	localparam int SW = DW + FRAC_SH;
	localparam int CW = $clog2(SW);
	localparam int QW = RES_W + 1;
	localparam logic [CW-1:0] LAST = CW'(SW - 1);

	logic          busy_q;
	logic          fin_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] dv_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] q_q;
	logic          ovf_q;
	logic          neg_q;
	logic [RES_W-1:0] quo_q;

	logic [DW-1:0] num_mag;
	logic [DW-1:0] rem_sh;
	logic          ge;
	logic [DW-1:0] rem_nx;
	logic          pos_sat;
	logic          neg_sat;

	assign num_mag = num[DW-1] ? (~num + DW'(1)) : num;

	// one long-division step; rem_q < den < 2^(DW-1) keeps the shift in range
	assign rem_sh = {rem_q[DW-2:0], dv_q[SW-1]};
	assign ge     = (rem_sh >= den_q);
	assign rem_nx = ge ? (rem_sh - den_q) : rem_sh;

	// saturation of the final magnitude
	assign pos_sat = ovf_q | q_q[QW-1] | q_q[QW-2];
	assign neg_sat = ovf_q | (q_q > {1'b0, RES_MIN});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= {num_mag, {FRAC_SH{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= num[DW-1];
		end else if (busy_q) begin
			dv_q  <= dv_q << 1;
			rem_q <= rem_nx;
			ovf_q <= ovf_q | q_q[QW-1];
			q_q   <= {q_q[QW-2:0], ge};
		end
		if (fin_q) begin
			if (neg_q)
				quo_q <= neg_sat ? RES_MIN : (~q_q[RES_W-1:0] + RES_W'(1));
			else
				quo_q <= pos_sat ? RES_MAX : q_q[RES_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

[hdl/lslf_datapath.sv]
// Datapath of the line fit: running sums, product and difference registers,
// the shared multiplier and divider, and the result register.
// Depends on lslf_pkg, lslf_mul, lslf_div.
`default_nettype none

module lslf_datapath
	import lslf_pkg::*;
#(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lslf_cmd_t             cmd,
	output lslf_sts_t                  sts,
	input  wire logic [X_W+Y_W-1:0]    in_data,
	output logic [2*RES_W-1:0]         out_data,
	output logic                       out_degen
);

	localparam int C     = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SXW   = X_W + C;
	localparam int SYW   = Y_W + C;
	localparam int SPW   = X_W + Y_W + C;
	localparam int AW    = SPW;
	localparam int BW    = (SXW > SYW) ? SXW : SYW;
	localparam int PW    = AW + BW + 1;
	localparam int DW    = PW + 1;

	// running sums
	logic [CNT_W-1:0] cnt_q;
	logic [SXW-1:0]   sx_q;
	logic [SYW-1:0]   sy_q;
	logic [SPW-1:0]   sxy_q;
	logic [SPW-1:0]   sxx_q;

	logic signed [X_W-1:0]     x;
	logic signed [Y_W-1:0]     y;
	logic signed [X_W+Y_W-1:0] xy;
	logic signed [X_W+Y_W-1:0] xx;

	assign x  = in_data[X_W-1:0];
	assign y  = in_data[X_W +: Y_W];
	assign xy = x * y;
	assign xx = x * x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
		end else if (cmd.acc_clr) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
		end else if (cmd.acc_en && (cnt_q < CNT_W'(MAX_POINTS))) begin
			// points beyond the capacity are dropped
			cnt_q <= cnt_q + CNT_W'(1);
			sx_q  <= sx_q + {{C{x[X_W-1]}}, x};
			sy_q  <= sy_q + {{C{y[Y_W-1]}}, y};
			sxy_q <= sxy_q + {{C{xy[X_W+Y_W-1]}}, xy};
			sxx_q <= sxx_q + {{C{xx[X_W+Y_W-1]}}, xx};
		end
	end

	// multiplier operand select: a is the wide factor, b the narrow one
	logic [AW-1:0] a_s;
	logic [BW:0]   b_s;
	logic [AW-1:0] a_mag;
	logic [BW:0]   b_abs;
	logic          mul_neg;
	logic          mul_done;
	logic [PW-1:0] prod;

	logic [AW-1:0] sx_a;
	logic [AW-1:0] sy_a;
	logic [BW:0]   n_b;
	logic [BW:0]   sx_b;
	logic [BW:0]   sy_b;

	assign sx_a = {{(AW-SXW){sx_q[SXW-1]}}, sx_q};
	assign sy_a = {{(AW-SYW){sy_q[SYW-1]}}, sy_q};
	assign n_b  = {{(BW+1-CNT_W){1'b0}}, cnt_q};
	assign sx_b = {{(BW+1-SXW){sx_q[SXW-1]}}, sx_q};
	assign sy_b = {{(BW+1-SYW){sy_q[SYW-1]}}, sy_q};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_N_SXX:  begin a_s = sxx_q; b_s = n_b;  end
			MUL_SX_SX:  begin a_s = sx_a;  b_s = sx_b; end
			MUL_N_SXY:  begin a_s = sxy_q; b_s = n_b;  end
			MUL_SX_SY:  begin a_s = sy_a;  b_s = sx_b; end
			MUL_SY_SXX: begin a_s = sxx_q; b_s = sy_b; end
			MUL_SX_SXY: begin a_s = sxy_q; b_s = sx_b; end
			default:    begin a_s = '0;    b_s = '0;   end
		endcase
	end

	assign a_mag   = a_s[AW-1] ? (~a_s + AW'(1)) : a_s;
	assign b_abs   = b_s[BW] ? (~b_s + (BW+1)'(1)) : b_s;
	assign mul_neg = a_s[AW-1] ^ b_s[BW];

	lslf_mul #(
		.AW(AW),
		.BW(BW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a_mag (a_mag),
		.b_mag (b_abs[BW-1:0]),
		.neg   (mul_neg),
		.done  (mul_done),
		.prod  (prod)
	);

	// product slots
	logic [PW-1:0] p_nsxx_q;
	logic [PW-1:0] p_sxsx_q;
	logic [PW-1:0] p_nsxy_q;
	logic [PW-1:0] p_sxsy_q;
	logic [PW-1:0] p_sysxx_q;
	logic [PW-1:0] p_sxsxy_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_store) begin
			unique case (cmd.mul_sel)
				MUL_N_SXX:  p_nsxx_q  <= prod;
				MUL_SX_SX:  p_sxsx_q  <= prod;
				MUL_N_SXY:  p_nsxy_q  <= prod;
				MUL_SX_SY:  p_sxsy_q  <= prod;
				MUL_SY_SXX: p_sysxx_q <= prod;
				MUL_SX_SXY: p_sxsxy_q <= prod;
				default:    ;
			endcase
		end
	end

	// denominator and the two numerators
	logic [DW-1:0] den_q;
	logic [DW-1:0] nums_q;
	logic [DW-1:0] numi_q;

	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			den_q  <= {p_nsxx_q[PW-1], p_nsxx_q} - {p_sxsx_q[PW-1], p_sxsx_q};
			nums_q <= {p_nsxy_q[PW-1], p_nsxy_q} - {p_sxsy_q[PW-1], p_sxsy_q};
			numi_q <= {p_sysxx_q[PW-1], p_sysxx_q} - {p_sxsxy_q[PW-1], p_sxsxy_q};
		end
	end

	logic den_pos;
	assign den_pos = ~den_q[DW-1] & (|den_q);

	// quotients
	logic [DW-1:0]    div_num;
	logic             div_done;
	logic [RES_W-1:0] quo;
	logic [RES_W-1:0] slope_q;
	logic [RES_W-1:0] icpt_q;

	assign div_num = (cmd.div_sel == DIV_SLOPE) ? nums_q : numi_q;

	lslf_div #(
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (den_q),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			if (cmd.div_sel == DIV_SLOPE)
				slope_q <= quo;
			else
				icpt_q <= quo;
		end
	end

	// result register, holds while the receiver stalls
	logic [RES_W-1:0] out_slope_q;
	logic [RES_W-1:0] out_icpt_q;
	logic             out_degen_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_slope_q <= den_pos ? slope_q : '0;
			out_icpt_q  <= den_pos ? icpt_q : '0;
			out_degen_q <= ~den_pos;
		end
	end

	assign out_data = {out_icpt_q, out_slope_q};
	assign out_degen = out_degen_q;

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.den_pos  = den_pos;

endmodule

`default_nettype wire

[hdl/lslf_ctrl.sv]
// Controller of the line fit: accumulation, product, quotient and output sequencing.
// Depends on lslf_pkg; drives lslf_datapath through lslf_cmd_t.
`default_nettype none

module lslf_ctrl
	import lslf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire logic      s_tlast,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire lslf_sts_t sts,
	output lslf_cmd_t      cmd
);

	localparam logic [2:0] S_ACC      = 3'd0;
	localparam logic [2:0] S_MUL_GO   = 3'd1;
	localparam logic [2:0] S_MUL_WAIT = 3'd2;
	localparam logic [2:0] S_DIFF     = 3'd3;
	localparam logic [2:0] S_CHECK    = 3'd4;
	localparam logic [2:0] S_DIV_GO   = 3'd5;
	localparam logic [2:0] S_DIV_WAIT = 3'd6;
	localparam logic [2:0] S_OUT      = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] k_q;
	logic [2:0] k_d;
	logic       d_q;
	logic       d_d;
	logic       valid_q;
	logic       accept;

	assign s_tready = (state_q == S_ACC);
	assign accept   = s_tready && s_tvalid;
	assign m_tvalid = valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		d_d     = d_q;
		cmd     = '0;
		cmd.mul_sel = k_q;
		cmd.div_sel = d_q;
		unique case (state_q)
			S_ACC: begin
				cmd.acc_en = accept;
				if (accept && s_tlast) begin
					k_d     = MUL_N_SXX;
					state_d = S_MUL_GO;
				end
			end
			S_MUL_GO: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					if (k_q == MUL_LAST) begin
						state_d = S_DIFF;
					end else begin
						k_d     = k_q + 3'd1;
						state_d = S_MUL_GO;
					end
				end
			end
			S_DIFF: begin
				// sums are no longer needed once all products are taken
				cmd.diff_en = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = S_CHECK;
			end
			S_CHECK: begin
				d_d     = DIV_SLOPE;
				state_d = sts.den_pos ? S_DIV_GO : S_OUT;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (d_q == DIV_ICPT) begin
						state_d = S_OUT;
					end else begin
						d_d     = DIV_ICPT;
						state_d = S_DIV_GO;
					end
				end
			end
			S_OUT: begin
				if (!valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_ACC;
				end
			end
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			k_q     <= MUL_N_SXX;
			d_q     <= DIV_SLOPE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			d_q     <= d_d;
			if (cmd.out_load)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire
